[rtl/sgdm_pkg.sv]
// shared types, widths, codes and helpers of the sgd momentum weight update engine
// no dependencies; imported by the top module, sgdm_csr and sgdm_div

package sgdm_pkg;

   localparam int DEF_SLOT_COUNT = 4096;

   localparam int W_W        = 32;
   localparam int FRAC       = 24;
   localparam int CFG_W      = 24;
   localparam int BLEN_W     = 16;
   localparam int SLOT_IDX_W = 12;
   localparam int MULT_W     = 32;
   localparam int LOSS_W     = 48;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SHR_W      = PROD_W - FRAC;
   localparam int L2_SHIFT   = 2 * FRAC + 1 - MUL_W;
   localparam int T2_W       = PROD_W - L2_SHIFT;
   localparam int NUM_W      = 41;
   localparam int NUMS_W     = NUM_W + 1;
   localparam int LRG_W      = 42;
   localparam int LR_SH      = MUL_W - FRAC;
   localparam int SAT_IN_W   = 45;
   localparam int REQ_W      = 2;

   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int REG_IX_W = CSR_AW - 2;

   localparam logic [REQ_W-1:0] REQ_ELEMENT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

   localparam logic [REG_IX_W-1:0] REG_STEP_RATE = 3'd0;
   localparam logic [REG_IX_W-1:0] REG_MOMENTUM  = 3'd1;
   localparam logic [REG_IX_W-1:0] REG_L1        = 3'd2;
   localparam logic [REG_IX_W-1:0] REG_L2        = 3'd3;
   localparam logic [REG_IX_W-1:0] REG_BATCH     = 3'd4;

   localparam logic [CFG_W-1:0]  RST_STEP_RATE = 24'd167772;
   localparam logic [CFG_W-1:0]  RST_MOMENTUM  = 24'd15099494;
   localparam logic [BLEN_W-1:0] RST_BATCH     = 16'd1;

   localparam logic signed [SAT_IN_W-1:0] SAT_HI =
      {{(SAT_IN_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
   localparam logic signed [SAT_IN_W-1:0] SAT_LO =
      {{(SAT_IN_W-W_W+1){1'b1}}, {(W_W-1){1'b0}}};

   typedef struct packed {
      logic [CFG_W-1:0]  step_rate;
      logic [CFG_W-1:0]  momentum_factor;
      logic [CFG_W-1:0]  l1_strength;
      logic [CFG_W-1:0]  l2_strength;
      logic [BLEN_W-1:0] batch_length;
   } cfg_type;

   function automatic logic signed [W_W-1:0] sat_w(logic signed [SAT_IN_W-1:0] v);
      logic signed [W_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[W_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[W_W-1:0];
      end else begin
         r = v[W_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [LOSS_W-1:0] acc_add(logic [LOSS_W-1:0] acc,
                                                  logic [LOSS_W-1:0] t);
      logic [LOSS_W:0] s;
      s = {1'b0, acc} + {1'b0, t};
      return s[LOSS_W] ? {LOSS_W{1'b1}} : s[LOSS_W-1:0];
   endfunction

endpackage

[rtl/sgd_momentum_weight_update.sv]
// element item: one item at a time; the bit-serial divider and a sequence of steps on the
// shared 32x32 multiplier lie between transfer in and result valid
// tick, clear and unused items: go straight from transfer in to the output state
// synchronous reset; afterwards the velocity ram is cleared slot by slot, no input taken
// depends on sgdm_pkg, sgdm_ram, sgdm_csr, sgdm_div

module sgd_momentum_weight_update
   import sgdm_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [REQ_W-1:0]             req_type,
   input  logic signed [W_W-1:0]        req_weight_in,
   input  logic signed [W_W-1:0]        req_grad_in,
   input  logic [SLOT_IDX_W-1:0]        req_slot_index,
   input  logic [MULT_W-1:0]            req_l1_mult,
   input  logic [MULT_W-1:0]            req_l2_mult,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [W_W-1:0]        rsp_weight_out,
   output logic                         rsp_update_due,
   output logic [LOSS_W-1:0]            rsp_l1_loss_total,
   output logic [LOSS_W-1:0]            rsp_l2_loss_total,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_AW-1:0]            csr_paddr,
   input  logic [CSR_DW-1:0]            csr_pwdata,
   output logic [CSR_DW-1:0]            csr_prdata,
   output logic                         csr_pready
);

   localparam int AW        = $clog2(SLOT_COUNT);
   localparam int MOD_SHIFT = 24;
   localparam int MOD_PW    = SLOT_IDX_W + MOD_SHIFT;
   localparam int RECIP     = ((1 << MOD_SHIFT) + SLOT_COUNT - 1) / SLOT_COUNT;

   typedef enum logic [17:0] {
      S_CLEAR = 18'h00001,
      S_IDLE  = 18'h00002,
      S_MODQ  = 18'h00004,
      S_MODR  = 18'h00008,
      S_RD    = 18'h00010,
      S_SQ    = 18'h00020,
      S_L1    = 18'h00040,
      S_L2G   = 18'h00080,
      S_PA    = 18'h00100,
      S_PB    = 18'h00200,
      S_NUM   = 18'h00400,
      S_DIV   = 18'h00800,
      S_LR0   = 18'h01000,
      S_LR1   = 18'h02000,
      S_LR2   = 18'h04000,
      S_MOM   = 18'h08000,
      S_WB    = 18'h10000,
      S_OUT   = 18'h20000
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff;

   logic signed [W_W-1:0] w_ff, g_ff;
   logic [SLOT_IDX_W-1:0] idx_ff, q_ff;
   logic [MULT_W-1:0]     l1m_ff, l2m_ff;
   logic [AW-1:0]         slot_ff;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod_ff;
   logic [MUL_W-1:0]  l1d_ff, l2d_ff;
   logic [PROD_W-1:0] sq_ff;
   logic [SHR_W-1:0]  l2g_mag_ff;
   logic [MUL_W-1:0]  pa_hi_ff;
   logic [T2_W-1:0]   t2_ff;
   logic              num_neg_ff;
   logic [SHR_W-1:0]  q0_hi_ff;
   logic [LRG_W-1:0]  lrg_mag_ff;
   logic signed [LRG_W:0] lrg_s_ff;
   logic signed [W_W-1:0] dx_ff;

   logic signed [W_W-1:0] res_weight_ff;
   logic                  res_due_ff;
   logic [BLEN_W-1:0]     iter_ff;
   logic [LOSS_W-1:0]     l1_acc_ff, l2_acc_ff;

   logic                  rsp_valid_ff;
   logic signed [W_W-1:0] rsp_weight_ff;
   logic                  rsp_due_ff;
   logic [LOSS_W-1:0]     rsp_l1_ff, rsp_l2_ff;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr;
   logic [W_W-1:0]        ram_wdata, ram_rdata;

   logic                  div_start, div_done;
   logic [NUM_W-1:0]      div_quo;

   logic                  in_xfer, out_free, mom_on;
   logic [BLEN_W-1:0]     blen_eff;
   logic [BLEN_W:0]       cnt_inc;
   logic [W_W-1:0]        aw, vel_mag, vm;
   logic [MOD_PW-1:0]     mod_prod;
   logic [SLOT_IDX_W-1:0] mod_sub, mod_rem;
   logic signed [SHR_W:0] l2g_s;
   logic signed [W_W:0]   l1g_s, vm_s;
   logic signed [NUM_W:0] num_s;
   logic [NUM_W-1:0]      num_mag;
   logic [LRG_W-1:0]      lrg_mag_in;
   logic signed [LRG_W:0] lrg_s_in;
   logic signed [SAT_IN_W-1:0] dx_sum, wv_sum, wl_sum;

   sgdm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sgdm_ram #(
      .WIDTH (W_W),
      .DEPTH (SLOT_COUNT)
   ) u_vel_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   sgdm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (blen_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // handshake and small combinational helpers
   assign req_ready = (state_ff == S_IDLE);
   assign in_xfer   = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign mom_on    = (cfg.momentum_factor != '0);
   assign blen_eff  = (cfg.batch_length == '0) ? BLEN_W'(1) : cfg.batch_length;
   assign cnt_inc   = {1'b0, iter_ff} + (BLEN_W+1)'(1);

   assign aw      = w_ff[W_W-1] ? (~w_ff + 1'b1) : w_ff;
   assign vel_mag = ram_rdata[W_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
   assign vm      = prod_ff[FRAC +: W_W];

   // slot modulo by reciprocal multiply
   assign mod_prod = MOD_PW'(idx_ff) * MOD_PW'(RECIP);
   assign mod_sub  = SLOT_IDX_W'(q_ff * SLOT_IDX_W'(SLOT_COUNT));
   assign mod_rem  = idx_ff - mod_sub;

   // raw gradient numerator
   assign l2g_s   = w_ff[W_W-1] ? -signed'({1'b0, l2g_mag_ff}) : signed'({1'b0, l2g_mag_ff});
   assign l1g_s   = (w_ff > 0) ? signed'({1'b0, l1d_ff}) : -signed'({1'b0, l1d_ff});
   assign num_s   = NUMS_W'(l2g_s) + NUMS_W'(l1g_s) + NUMS_W'(g_ff);
   assign num_mag = num_s[NUM_W] ? NUM_W'(-num_s) : NUM_W'(num_s);
   assign div_start = (state_ff == S_NUM);

   // learning-rate product and velocity update
   assign lrg_mag_in = {prod_ff[LRG_W-LR_SH-1:0], {LR_SH{1'b0}}} + LRG_W'(q0_hi_ff);
   assign lrg_s_in   = num_neg_ff ? -signed'({1'b0, lrg_mag_ff}) : signed'({1'b0, lrg_mag_ff});
   assign vm_s       = ram_rdata[W_W-1] ? -signed'({1'b0, vm}) : signed'({1'b0, vm});
   assign dx_sum     = SAT_IN_W'(vm_s) - SAT_IN_W'(lrg_s_in);
   assign wv_sum     = SAT_IN_W'(w_ff) + SAT_IN_W'(dx_ff);
   assign wl_sum     = SAT_IN_W'(w_ff) - SAT_IN_W'(lrg_s_ff);

   // ram ports
   assign ram_re    = (state_ff == S_RD);
   assign ram_we    = (state_ff == S_CLEAR) | ((state_ff == S_WB) & mom_on);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : slot_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 : dx_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MODQ: begin
            mul_a = MUL_W'(cfg.l1_strength);
            mul_b = l1m_ff;
         end
         S_MODR: begin
            mul_a = MUL_W'(cfg.l2_strength);
            mul_b = l2m_ff;
         end
         S_RD: begin
            mul_a = aw;
            mul_b = aw;
         end
         S_SQ: begin
            mul_a = l1d_ff;
            mul_b = aw;
         end
         S_L1: begin
            mul_a = l2d_ff;
            mul_b = aw;
         end
         S_L2G: begin
            mul_a = l2d_ff;
            mul_b = sq_ff[MUL_W-1:0];
         end
         S_PA: begin
            mul_a = l2d_ff;
            mul_b = sq_ff[PROD_W-1:MUL_W];
         end
         S_LR0: begin
            mul_a = div_quo[MUL_W-1:0];
            mul_b = MUL_W'(cfg.step_rate);
         end
         S_LR1: begin
            mul_a = MUL_W'(div_quo[NUM_W-1:MUL_W]);
            mul_b = MUL_W'(cfg.step_rate);
         end
         S_LR2: begin
            mul_a = vel_mag;
            mul_b = MUL_W'(cfg.momentum_factor);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(SLOT_COUNT - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (in_xfer) begin
               state_in = (req_type == REQ_ELEMENT) ? S_MODQ : S_OUT;
            end
         end
         S_MODQ: state_in = S_MODR;
         S_MODR: state_in = S_RD;
         S_RD:   state_in = S_SQ;
         S_SQ:   state_in = S_L1;
         S_L1:   state_in = S_L2G;
         S_L2G:  state_in = S_PA;
         S_PA:   state_in = S_PB;
         S_PB:   state_in = S_NUM;
         S_NUM:  state_in = S_DIV;
         S_DIV:  if (div_done) state_in = S_LR0;
         S_LR0:  state_in = S_LR1;
         S_LR1:  state_in = S_LR2;
         S_LR2:  state_in = S_MOM;
         S_MOM:  state_in = S_WB;
         S_WB:   state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         iter_ff      <= '0;
         l1_acc_ff    <= '0;
         l2_acc_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (in_xfer) begin
            case (req_type)
               REQ_TICK: begin
                  iter_ff <= (cnt_inc >= {1'b0, blen_eff}) ? '0 : cnt_inc[BLEN_W-1:0];
               end
               REQ_CLEAR: begin
                  l1_acc_ff <= '0;
                  l2_acc_ff <= '0;
               end
               default: ;
            endcase
         end
         if (state_ff == S_L1) begin
            l1_acc_ff <= acc_add(l1_acc_ff, LOSS_W'(prod_ff[PROD_W-1:FRAC]));
         end
         if (state_ff == S_NUM) begin
            l2_acc_ff <= acc_add(l2_acc_ff, LOSS_W'(t2_ff));
         end
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (in_xfer) begin
         w_ff          <= req_weight_in;
         g_ff          <= req_grad_in;
         idx_ff        <= req_slot_index;
         l1m_ff        <= req_l1_mult;
         l2m_ff        <= req_l2_mult;
         res_weight_ff <= '0;
         res_due_ff    <= (req_type == REQ_TICK) && (cnt_inc >= {1'b0, blen_eff});
      end
      case (state_ff)
         S_MODQ: q_ff <= mod_prod[MOD_PW-1:MOD_SHIFT];
         S_MODR: begin
            l1d_ff  <= prod_ff[FRAC +: MUL_W];
            slot_ff <= AW'(mod_rem);
         end
         S_RD:  l2d_ff     <= prod_ff[FRAC +: MUL_W];
         S_SQ:  sq_ff      <= prod_ff;
         S_L2G: l2g_mag_ff <= prod_ff[PROD_W-1:FRAC];
         S_PA:  pa_hi_ff   <= prod_ff[PROD_W-1:MUL_W];
         S_PB: begin
            t2_ff <= T2_W'((prod_ff + PROD_W'(pa_hi_ff)) >> L2_SHIFT);
         end
         S_NUM: num_neg_ff <= num_s[NUM_W];
         S_LR1: q0_hi_ff   <= prod_ff[PROD_W-1:FRAC];
         S_LR2: lrg_mag_ff <= lrg_mag_in;
         S_MOM: begin
            lrg_s_ff <= lrg_s_in;
            dx_ff    <= sat_w(dx_sum);
         end
         S_WB: res_weight_ff <= mom_on ? sat_w(wv_sum) : sat_w(wl_sum);
         default: ;
      endcase
      if ((state_ff == S_OUT) && out_free) begin
         rsp_weight_ff <= res_weight_ff;
         rsp_due_ff    <= res_due_ff;
         rsp_l1_ff     <= l1_acc_ff;
         rsp_l2_ff     <= l2_acc_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_weight_out    = rsp_weight_ff;
   assign rsp_update_due    = rsp_due_ff;
   assign rsp_l1_loss_total = rsp_l1_ff;
   assign rsp_l2_loss_total = rsp_l2_ff;

endmodule

[rtl/sgdm_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module sgdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sgdm_csr.sv]
// apb-style configuration registers of the sgd momentum weight update engine
// depends on sgdm_pkg

module sgdm_csr
   import sgdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type               cfg_ff;
   logic [REG_IX_W-1:0]   reg_ix;
   logic                  wr_en;

   assign reg_ix = paddr[CSR_AW-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_rate       <= RST_STEP_RATE;
         cfg_ff.momentum_factor <= RST_MOMENTUM;
         cfg_ff.l1_strength     <= '0;
         cfg_ff.l2_strength     <= '0;
         cfg_ff.batch_length    <= RST_BATCH;
      end else if (wr_en) begin
         unique case (reg_ix)
            REG_STEP_RATE: cfg_ff.step_rate       <= pwdata[CFG_W-1:0];
            REG_MOMENTUM:  cfg_ff.momentum_factor <= pwdata[CFG_W-1:0];
            REG_L1:        cfg_ff.l1_strength     <= pwdata[CFG_W-1:0];
            REG_L2:        cfg_ff.l2_strength     <= pwdata[CFG_W-1:0];
            REG_BATCH:     cfg_ff.batch_length    <= pwdata[BLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_ix)
         REG_STEP_RATE: prdata = CSR_DW'(cfg_ff.step_rate);
         REG_MOMENTUM:  prdata = CSR_DW'(cfg_ff.momentum_factor);
         REG_L1:        prdata = CSR_DW'(cfg_ff.l1_strength);
         REG_L2:        prdata = CSR_DW'(cfg_ff.l2_strength);
         REG_BATCH:     prdata = CSR_DW'(cfg_ff.batch_length);
         default:       prdata = '0;
      endcase
   end

endmodule

[rtl/sgdm_div.sv]
// bit-serial restoring divider for the gradient-by-batch-length division
// depends on sgdm_pkg

module sgdm_div
   import sgdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [BLEN_W-1:0] divisor,
   output logic              done,
   output logic [NUM_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [BLEN_W-1:0] rem_ff;
   logic [BLEN_W-1:0] dvs_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [BLEN_W:0]   rem_sh;
   logic [BLEN_W:0]   diff;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? diff[BLEN_W-1:0] : rem_sh[BLEN_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
